### src/pft_pkg.sv
// ----------------------------------------------------------------------------
// pft_pkg
// Shared types and constants for the pareto front table: request and result
// words, the stored entry and the token that sweeps the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pft_pkg;

    localparam int FRONT_DEPTH_DEF = 32;
    localparam int CNT_W           = 6;
    localparam int VAL_W           = 16;

    typedef enum logic [2:0] {
        ST_KEPT      = 3'd0,
        ST_DOMINATED = 3'd1,
        ST_EVICTED   = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_ABSENT    = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        OP_SCAN   = 2'd0,
        OP_EVICT  = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef struct packed {
        logic             req_type;
        logic [VAL_W-1:0] point_id;
        logic [VAL_W-1:0] error_value;
        logic [VAL_W-1:0] complexity;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [VAL_W-1:0] out_id;
        logic [VAL_W-1:0] out_error;
        logic [VAL_W-1:0] out_complexity;
        logic [CNT_W-1:0] front_count;
        logic             last_result;
    } rsp_t;

    typedef struct packed {
        logic [VAL_W-1:0] ident;
        logic [VAL_W-1:0] err;
        logic [VAL_W-1:0] cx;
    } ent_t;

    typedef struct packed {
        logic             live;
        op_t              op;
        logic             dom;
        logic [CNT_W-1:0] evcnt;
        logic             free;
        logic             placed;
        logic             done;
    } tok_t;

endpackage

`default_nettype wire

### src/pareto_front_table.sv
// ----------------------------------------------------------------------------
// pareto_front_table
// Bounded table of non-dominated (error, complexity) points built as a row
// of cells that a single sweep token walks through.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle. A remove walks the row
// once. An insert walks it once to find dominance, the eviction count and a
// free slot; a dominated insert then ends, any other insert walks it again
// to evict and place. The token moves one cell per cycle, but stays in a
// cell while a stalled output holds back the result that cell reports.
// Results leave through a one-word output register, so a new request can
// be taken while the last word still waits.
`default_nettype none

module pareto_front_table
    import pft_pkg::*;
#(
    parameter int FRONT_DEPTH = FRONT_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t req,
    input  wire logic req_valid,
    output logic      req_stall,
    output rsp_t      rsp,
    output logic      rsp_valid,
    input  wire logic rsp_stall
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_EVICT  = 5'b00100,
        S_REMOVE = 5'b01000,
        S_FINAL  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    ent_t             cand_reg, cand_next;
    rsp_t             fin_reg, fin_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    rsp_t             out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    tok_t             tok_link [FRONT_DEPTH+1];
    logic [FRONT_DEPTH-1:0] emit_vec;
    ent_t             emit_arr [FRONT_DEPTH];
    ent_t             emit_ent;
    tok_t             inj, tail;
    logic             can_load, emit_any, kept;

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp         = out_reg;
    assign rsp_valid   = out_valid_reg;
    assign can_load    = !out_valid_reg || !rsp_stall;
    assign tok_link[0] = inj;
    assign tail        = tok_link[FRONT_DEPTH];
    assign emit_any    = |emit_vec;

    for (genvar i = 0; i < FRONT_DEPTH; i++)
    begin : g_cell
        pft_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cand     (cand_reg),
            .tok_in   (tok_link[i]),
            .hold     (!can_load),
            .tok_out  (tok_link[i+1]),
            .emit     (emit_vec[i]),
            .emit_ent (emit_arr[i])
        );
    end

    always_comb
    begin
        emit_ent = '0;
        for (int i = 0; i < FRONT_DEPTH; i++)
        begin
            emit_ent = emit_ent | emit_arr[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cand_next      = cand_reg;
        fin_next       = fin_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        inj            = '0;
        kept           = tail.free || (tail.evcnt != '0);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cand_next.ident = req.point_id;
                    cand_next.err   = req.error_value;
                    cand_next.cx    = req.complexity;
                    inj.live        = 1'b1;
                    inj.op          = req.req_type ? OP_REMOVE : OP_SCAN;
                    state_next      = req.req_type ? S_REMOVE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tail.live)
                begin
                    fin_next.out_id         = cand_reg.ident;
                    fin_next.out_error      = cand_reg.err;
                    fin_next.out_complexity = cand_reg.cx;
                    fin_next.last_result    = 1'b1;
                    if (tail.dom)
                    begin
                        fin_next.status      = ST_DOMINATED;
                        fin_next.front_count = cnt_reg;
                        state_next           = S_FINAL;
                    end
                    else
                    begin
                        fin_next.status      = kept ? ST_KEPT : ST_FULL;
                        fin_next.front_count = cnt_reg - tail.evcnt
                                             + (kept ? CNT_W'(1) : CNT_W'(0));
                        inj.live             = 1'b1;
                        inj.op               = OP_EVICT;
                        state_next           = S_EVICT;
                    end
                end
            end
            S_EVICT:
            begin
                if (emit_any && can_load)
                begin
                    out_valid_next          = 1'b1;
                    out_next.status         = ST_EVICTED;
                    out_next.out_id         = emit_ent.ident;
                    out_next.out_error      = emit_ent.err;
                    out_next.out_complexity = emit_ent.cx;
                    out_next.front_count    = fin_reg.front_count;
                    out_next.last_result    = 1'b0;
                end
                if (tail.live)
                begin
                    state_next = S_FINAL;
                end
            end
            S_REMOVE:
            begin
                if (emit_any && can_load)
                begin
                    out_valid_next          = 1'b1;
                    out_next.status         = ST_REMOVED;
                    out_next.out_id         = emit_ent.ident;
                    out_next.out_error      = emit_ent.err;
                    out_next.out_complexity = emit_ent.cx;
                    out_next.front_count    = cnt_reg - CNT_W'(1);
                    out_next.last_result    = 1'b1;
                end
                if (tail.live)
                begin
                    if (tail.done)
                    begin
                        cnt_next   = cnt_reg - CNT_W'(1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        fin_next.status         = ST_ABSENT;
                        fin_next.out_id         = cand_reg.ident;
                        fin_next.out_error      = '0;
                        fin_next.out_complexity = '0;
                        fin_next.front_count    = cnt_reg;
                        fin_next.last_result    = 1'b1;
                        state_next              = S_FINAL;
                    end
                end
            end
            S_FINAL:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_next       = fin_reg;
                    cnt_next       = fin_reg.front_count;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        fin_reg  <= fin_next;
        out_reg  <= out_next;
    end

    // only the cell holding the token may report an entry
    a_one_emitter: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(emit_vec))
        else $error("more than one cell reports an entry");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (emit_vec == '0) && !tail.live)
        else $error("cell activity while idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FRONT_DEPTH))
        else $error("front count above depth");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> (state_reg == S_SCAN) || (state_reg == S_REMOVE))
        else $error("accepted request did not start a sweep");

endmodule

`default_nettype wire

### src/pft_cell.sv
// ----------------------------------------------------------------------------
// pft_cell
// One slot of the front. Holds an entry, compares it with the broadcast
// candidate while the sweep token sits here, and hands the token on.
// ----------------------------------------------------------------------------
`default_nettype none

module pft_cell
    import pft_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire ent_t cand,
    input  wire tok_t tok_in,
    input  wire logic hold,
    output tok_t      tok_out,
    output logic      emit,
    output ent_t      emit_ent
);

    ent_t ent_reg, ent_next;
    logic valid_reg, valid_next;
    tok_t tok_reg, tok_next;

    logic same, dom_me, ev_me, id_hit, move;

    always_comb
    begin
        same   = (ent_reg.err == cand.err) && (ent_reg.cx == cand.cx);
        dom_me = valid_reg && (ent_reg.err <= cand.err) && (ent_reg.cx <= cand.cx) && !same;
        ev_me  = valid_reg && (cand.err <= ent_reg.err) && (cand.cx <= ent_reg.cx) && !same;
        id_hit = valid_reg && (ent_reg.ident == cand.ident);

        emit = 1'b0;
        if (tok_reg.live)
        begin
            unique case (tok_reg.op)
                OP_EVICT:  emit = ev_me;
                OP_REMOVE: emit = id_hit && !tok_reg.done;
                default:   emit = 1'b0;
            endcase
        end
        move     = tok_reg.live && !(emit && hold);
        emit_ent = emit ? ent_reg : '0;

        tok_out    = tok_reg;
        valid_next = valid_reg;
        ent_next   = ent_reg;
        unique case (tok_reg.op)
            OP_SCAN:
            begin
                tok_out.dom   = tok_reg.dom | dom_me;
                tok_out.evcnt = tok_reg.evcnt + (ev_me ? CNT_W'(1) : CNT_W'(0));
                tok_out.free  = tok_reg.free | !valid_reg;
            end
            OP_EVICT:
            begin
                if (move && ev_me)
                begin
                    valid_next = 1'b0;
                end
                if (move && !tok_reg.placed && (!valid_reg || ev_me))
                begin
                    ent_next       = cand;
                    valid_next     = 1'b1;
                    tok_out.placed = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (move && emit)
                begin
                    valid_next   = 1'b0;
                    tok_out.done = 1'b1;
                end
            end
            default:
            begin
                tok_out = tok_reg;
            end
        endcase
        tok_out.live = move;

        if (tok_in.live)
        begin
            tok_next = tok_in;
        end
        else if (move)
        begin
            tok_next = '0;
        end
        else
        begin
            tok_next = tok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pareto_front_table. A local copy of the front table
// predicts the result words of every accepted request; a monitor compares each
// result word field by field with the oldest prediction. Directed tests cover
// the corner cases, then random traffic runs under several idle patterns and a
// long output hold-off.
// ----------------------------------------------------------------------------
module tb_top
    import pft_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = FRONT_DEPTH_DEF;
    localparam int LIMIT = 400000;
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    logic clk;
    logic rst_n;
    req_t req;
    logic req_valid;
    logic req_stall;
    rsp_t rsp;
    logic rsp_valid;
    logic rsp_stall;

    // local copy of the front
    logic [VAL_W-1:0] front_err [DEPTH];
    logic [VAL_W-1:0] front_cx [DEPTH];
    logic [VAL_W-1:0] front_id [DEPTH];
    logic             front_live [DEPTH];

    rsp_t pending_words[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int n_mismatch = 0;
    int n_requests = 0;
    int n_words = 0;
    int cycle_cnt = 0;
    int status_seen [6];

    pareto_front_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("** pareto_front_table: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic rsp_t make_word(status_t st, logic [VAL_W-1:0] id,
                                       logic [VAL_W-1:0] e, logic [VAL_W-1:0] c);
        rsp_t w;
        w = '0;
        w.status = st;
        w.out_id = id;
        w.out_error = e;
        w.out_complexity = c;
        return w;
    endfunction

    function automatic req_t mk_req(logic op, logic [VAL_W-1:0] id,
                                    logic [VAL_W-1:0] e, logic [VAL_W-1:0] c);
        req_t r;
        r.req_type = op;
        r.point_id = id;
        r.error_value = e;
        r.complexity = c;
        return r;
    endfunction

    // apply one request to the local front and queue the words it causes
    function automatic void update_front(req_t r);
        rsp_t words[$];
        rsp_t w;
        logic dominated;
        logic same;
        int slot;
        int hit;
        int live_cnt;
        dominated = 1'b0;
        slot = -1;
        hit = -1;
        live_cnt = 0;
        if (r.req_type == REQ_INSERT)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                same = (front_err[i] == r.error_value) && (front_cx[i] == r.complexity);
                if (front_live[i] && front_err[i] <= r.error_value &&
                    front_cx[i] <= r.complexity && !same)
                    dominated = 1'b1;
            end
            if (dominated)
                words.push_back(make_word(ST_DOMINATED, r.point_id, r.error_value,
                                          r.complexity));
            else
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    same = (front_err[i] == r.error_value) && (front_cx[i] == r.complexity);
                    if (front_live[i] && r.error_value <= front_err[i] &&
                        r.complexity <= front_cx[i] && !same)
                    begin
                        words.push_back(make_word(ST_EVICTED, front_id[i], front_err[i],
                                                  front_cx[i]));
                        front_live[i] = 1'b0;
                    end
                end
                for (int i = 0; i < DEPTH; i++)
                    if (!front_live[i] && slot < 0)
                        slot = i;
                if (slot >= 0)
                begin
                    front_err[slot] = r.error_value;
                    front_cx[slot] = r.complexity;
                    front_id[slot] = r.point_id;
                    front_live[slot] = 1'b1;
                    words.push_back(make_word(ST_KEPT, r.point_id, r.error_value,
                                              r.complexity));
                end
                else
                    words.push_back(make_word(ST_FULL, r.point_id, r.error_value,
                                              r.complexity));
            end
        end
        else
        begin
            for (int i = 0; i < DEPTH; i++)
                if (front_live[i] && front_id[i] == r.point_id && hit < 0)
                    hit = i;
            if (hit >= 0)
            begin
                front_live[hit] = 1'b0;
                words.push_back(make_word(ST_REMOVED, front_id[hit], front_err[hit],
                                          front_cx[hit]));
            end
            else
                words.push_back(make_word(ST_ABSENT, r.point_id, '0, '0));
        end
        for (int i = 0; i < DEPTH; i++)
            if (front_live[i])
                live_cnt++;
        foreach (words[k])
        begin
            w = words[k];
            w.front_count = CNT_W'(live_cnt);
            w.last_result = (k == words.size() - 1);
            pending_words.push_back(w);
        end
    endfunction

    function automatic void check_word(rsp_t got);
        rsp_t want;
        n_words++;
        if (int'(got.status) < 6)
            status_seen[int'(got.status)]++;
        if (pending_words.size() == 0)
        begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("%0t unexpected word st=%0d id=%h err=%h cx=%h cnt=%0d last=%b",
                         $realtime, got.status, got.out_id, got.out_error,
                         got.out_complexity, got.front_count, got.last_result);
            return;
        end
        want = pending_words.pop_front();
        if (got.status !== want.status || got.out_id !== want.out_id ||
            got.out_error !== want.out_error || got.out_complexity !== want.out_complexity ||
            got.front_count !== want.front_count || got.last_result !== want.last_result)
        begin
            n_mismatch++;
            if (n_mismatch <= 10)
            begin
                $display("%0t mismatch want st=%0d id=%h err=%h cx=%h cnt=%0d last=%b",
                         $realtime, want.status, want.out_id, want.out_error,
                         want.out_complexity, want.front_count, want.last_result);
                $display("%0t          got  st=%0d id=%h err=%h cx=%h cnt=%0d last=%b",
                         $realtime, got.status, got.out_id, got.out_error,
                         got.out_complexity, got.front_count, got.last_result);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                check_word(rsp);
            if (req_valid && !req_stall)
            begin
                update_front(req);
                n_requests++;
            end
        end
    end

    function automatic int pick_live();
        int live[$];
        for (int i = 0; i < DEPTH; i++)
            if (front_live[i])
                live.push_back(i);
        if (live.size() == 0)
            return -1;
        return live[$urandom_range(live.size() - 1)];
    endfunction

    // points near a diagonal front, removes mostly of live ids, copies of live points and noise
    function automatic req_t random_request();
        req_t r;
        int roll;
        int slot;
        int e;
        int c;
        roll = $urandom_range(99);
        r = mk_req(REQ_INSERT, $urandom_range(1) ? 16'($urandom_range(63)) : 16'($urandom),
                   16'($urandom), 16'($urandom));
        if (roll < 25)
        begin
            r.req_type = REQ_REMOVE;
            slot = pick_live();
            if (slot >= 0 && $urandom_range(99) < 70)
                r.point_id = front_id[slot];
        end
        else if (roll < 70)
        begin
            e = $urandom_range(65535);
            c = 65535 - e + int'($urandom_range(4095)) - 2048;
            if (c < 0)
                c = 0;
            if (c > 65535)
                c = 65535;
            r.error_value = 16'(e);
            r.complexity = 16'(c);
        end
        else if (roll < 80)
        begin
            slot = pick_live();
            if (slot >= 0)
            begin
                r.error_value = front_err[slot];
                r.complexity = front_cx[slot];
            end
        end
        else if (roll < 90)
        begin
            r.error_value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            r.complexity = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
        return r;
    endfunction

    task automatic send_word(req_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            if (req_valid)
                req_valid <= 1'b0;
            @(posedge clk);
        end
        req <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        if (req_valid)
            req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
    endtask

    task automatic test_directed();
        send_word(mk_req(REQ_REMOVE, 16'd5, 16'hFFFF, 16'hFFFF));
        send_word(mk_req(REQ_INSERT, 16'd1, 16'h0000, 16'hFFFF));
        send_word(mk_req(REQ_INSERT, 16'd2, 16'hFFFF, 16'h0000));
        send_word(mk_req(REQ_INSERT, 16'd3, 16'h0000, 16'hFFFF));
        send_word(mk_req(REQ_INSERT, 16'd4, 16'hFFFF, 16'hFFFF));
        send_word(mk_req(REQ_INSERT, 16'd5, 16'h8000, 16'h8000));
        send_word(mk_req(REQ_INSERT, 16'd6, 16'h4000, 16'h4000));
        send_word(mk_req(REQ_INSERT, 16'hFFFF, 16'd40000, 16'd100));
        send_word(mk_req(REQ_INSERT, 16'hA5A5, 16'hAAAA, 16'h5555));
        send_word(mk_req(REQ_REMOVE, 16'd3, 16'h0000, 16'h0000));
        send_word(mk_req(REQ_REMOVE, 16'd3, 16'h5A5A, 16'hA5A5));
        send_word(mk_req(REQ_INSERT, 16'd7, 16'h0000, 16'h0000));
        send_word(mk_req(REQ_REMOVE, 16'd7, 16'h0000, 16'h0000));
        send_word(mk_req(REQ_REMOVE, 16'hFFFF, 16'h0000, 16'h0000));
        send_word(mk_req(REQ_INSERT, 16'd9, 16'd100, 16'd200));
        send_word(mk_req(REQ_INSERT, 16'd9, 16'd200, 16'd100));
        send_word(mk_req(REQ_REMOVE, 16'd9, 16'h0000, 16'h0000));
        send_word(mk_req(REQ_REMOVE, 16'd0, 16'h0000, 16'h0000));
        send_word(mk_req(REQ_INSERT, 16'd0, 16'hFFFF, 16'hFFFF));
        send_word(mk_req(REQ_INSERT, 16'd0, 16'h0000, 16'hFFFF));
        wait_idle();
    endtask

    task automatic test_full_table();
        logic [VAL_W-1:0] ids[$];
        wait_idle();
        for (int i = 0; i < DEPTH; i++)
            if (front_live[i])
                ids.push_back(front_id[i]);
        foreach (ids[k])
            send_word(mk_req(REQ_REMOVE, ids[k], 16'($urandom), 16'($urandom)));
        // staircase that fills every slot
        for (int i = 0; i < DEPTH; i++)
            send_word(mk_req(REQ_INSERT, 16'(16'h0100 + i), 16'(2000 * i),
                             16'(2000 * (DEPTH - 1) - 2000 * i)));
        send_word(mk_req(REQ_INSERT, 16'h0200, 16'd1000,
                         16'(2000 * (DEPTH - 1) - 1000)));
        send_word(mk_req(REQ_INSERT, 16'h0201, 16'(2000 * 5),
                         16'(2000 * (DEPTH - 1) - 2000 * 5)));
        // sweeps the whole table out
        send_word(mk_req(REQ_INSERT, 16'h0202, 16'h0000, 16'h0000));
        send_word(mk_req(REQ_REMOVE, 16'h0202, 16'h0000, 16'h0000));
        wait_idle();
    endtask

    task automatic test_random_phase(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n)
            send_word(random_request());
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_left = 400;
        repeat (12)
            send_word(random_request());
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req = '0;
        req_valid = 1'b0;
        foreach (front_live[i])
            front_live[i] = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 38;
        recv_idle_pct = 52;
        test_directed();
        test_full_table();
        test_random_phase(115, 38, 52);
        test_backpressure();
        test_random_phase(115, 52, 38);
        test_random_phase(115, 0, 0);

        wait_idle();
        repeat (2 * DEPTH + 16)
            @(posedge clk);

        $display("run covered %0d requests and %0d result words in %0d cycles",
                 n_requests, n_words, cycle_cnt);
        $display("kept %0d, dominated %0d, evicted %0d, removed %0d, absent %0d, full %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (n_mismatch == 0 && pending_words.size() == 0)
            $display("** pareto_front_table: PASSED **");
        else
        begin
            $display("%0d mismatches, %0d words outstanding", n_mismatch,
                     pending_words.size());
            $display("** pareto_front_table: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
src/pft_pkg.sv
src/pft_cell.sv
src/pareto_front_table.sv
tb/tb_top.sv
